// ----- src/msp_afs_pkg.sv -----
// Shared types, protocol constants and the frame byte table of the MSP arming frame sender.
package msp_afs_pkg;

  localparam logic [7:0] HdrDollar = 8'h24;
  localparam logic [7:0] HdrM      = 8'h4D;
  localparam logic [7:0] HdrLt     = 8'h3C;

  localparam logic [7:0] CmdApiVersion = 8'd1;
  localparam logic [7:0] CmdStatus     = 8'd101;
  localparam logic [7:0] CmdSetArming  = 8'd214;

  localparam int unsigned CfgW = 16;
  localparam int unsigned TimeW = 32;

  localparam logic [CfgW-1:0] BootDelayReset    = 16'd3000;
  localparam logic [CfgW-1:0] SendIntervalReset = 16'd500;

  // Register select bit of the configuration address (paddr[2]).
  localparam logic RegBootDelay    = 1'b0;
  localparam logic RegSendInterval = 1'b1;

  localparam int unsigned BeatIdxW = 4;
  localparam logic [BeatIdxW-1:0] HandshakeLastIdx = 4'd11;
  localparam logic [BeatIdxW-1:0] ArmingLastIdx    = 4'd6;
  localparam logic [BeatIdxW-1:0] FrameLen0        = 4'd6;

  typedef enum logic {
    FK_HANDSHAKE = 1'b0,
    FK_ARMING    = 1'b1
  } frame_kind_e;

  typedef struct packed {
    frame_kind_e kind;
    logic        armed;
  } q_entry_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_last;
    logic       run_last;
  } out_beat_t;

  // Byte number idx of the run that one queued entry stands for.
  function automatic out_beat_t frame_beat(input q_entry_t e, input logic [BeatIdxW-1:0] idx);
    logic                second;
    logic [BeatIdxW-1:0] p;
    logic [7:0]          cmd;
    logic [7:0]          size;
    logic [7:0]          payload;
    out_beat_t           b;
    second  = (e.kind == FK_HANDSHAKE) && (idx >= FrameLen0);
    p       = second ? (idx - FrameLen0) : idx;
    cmd     = (e.kind == FK_ARMING) ? CmdSetArming : (second ? CmdStatus : CmdApiVersion);
    size    = (e.kind == FK_ARMING) ? 8'd1 : 8'd0;
    payload = {7'b0, e.armed};
    b.frame_last = 1'b0;
    case (p)
      4'd0: b.tx_byte = HdrDollar;
      4'd1: b.tx_byte = HdrM;
      4'd2: b.tx_byte = HdrLt;
      4'd3: b.tx_byte = size;
      4'd4: b.tx_byte = cmd;
      4'd5: begin
        if (e.kind == FK_HANDSHAKE) begin
          b.tx_byte    = size ^ cmd;
          b.frame_last = 1'b1;
        end else begin
          b.tx_byte = payload;
        end
      end
      4'd6: begin
        b.tx_byte    = size ^ cmd ^ payload;
        b.frame_last = 1'b1;
      end
      default: b.tx_byte = 8'h00;
    endcase
    b.run_last = (e.kind == FK_HANDSHAKE) ? (idx == HandshakeLastIdx) : (idx == ArmingLastIdx);
    return b;
  endfunction

endpackage

// ----- src/msp_arming_frame_sender.sv -----
// Top level of the MSP arming frame sender: configuration registers and the three stages.
//
// Slave stream: one beat per update, s_axis_tdata = now_ms in bits 31:0, armed in bit 32.
// Master stream: one beat per serial byte; m_axis_tlast marks the checksum byte of a frame,
// m_axis_tuser marks the last byte caused by one update.
// The APB port holds boot_delay_ms at address 0 and send_interval_ms at address 4;
// write them only while no bytes are pending.
// Before now_ms reaches the boot delay an update yields nothing. The first update after
// that yields the API version and status frames (12 bytes); later updates yield a
// 7-byte set-arming frame whenever the wrapped elapsed time reaches the send interval.
// An update is queued, then its first byte loads the output register behind m_axis_tvalid.
// Throughput: the byte sequencer emits one byte per cycle while the receiver is ready, and
// an update costs 12 bytes (handshake), 7 (arming) or none (nothing sent) of the output.
// A request queue of QueueDepth entries lets updates be taken while earlier frames still
// drain; s_axis_tready falls only when that queue is full.
// When the receiver stalls, the output register holds its byte and the queue fills.
// Reset clears the handshake flag, the last send time, the queue and the output stage,
// and loads the register defaults 3000 and 500.
module msp_arming_frame_sender #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // now_ms[31:0], armed[32], zero fill [39:33]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // tx_byte[7:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // run_last[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [msp_afs_pkg::CfgW-1:0] boot_delay_q, send_interval_q;
  logic                         cfg_we;

  logic                   push_valid, push_ready;
  msp_afs_pkg::q_entry_t  push_entry;
  logic                   pop_valid, pop_ready;
  msp_afs_pkg::q_entry_t  pop_entry;
  msp_afs_pkg::out_beat_t out_beat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_delay_q    <= msp_afs_pkg::BootDelayReset;
      send_interval_q <= msp_afs_pkg::SendIntervalReset;
    end else if (cfg_we) begin
      if (paddr[2] == msp_afs_pkg::RegBootDelay) begin
        boot_delay_q <= pwdata[msp_afs_pkg::CfgW-1:0];
      end else begin
        send_interval_q <= pwdata[msp_afs_pkg::CfgW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == msp_afs_pkg::RegSendInterval) begin
      prdata = {{(32-msp_afs_pkg::CfgW){1'b0}}, send_interval_q};
    end else begin
      prdata = {{(32-msp_afs_pkg::CfgW){1'b0}}, boot_delay_q};
    end
  end

  msp_afs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .now_ms_i        (s_axis_tdata[31:0]),
    .armed_i         (s_axis_tdata[32]),
    .boot_delay_i    (boot_delay_q),
    .send_interval_i (send_interval_q),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_entry_o    (push_entry)
  );

  msp_afs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  msp_afs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_beat_o  (out_beat)
  );

  assign m_axis_tdata = out_beat.tx_byte;
  assign m_axis_tlast = out_beat.frame_last;
  assign m_axis_tuser = out_beat.run_last;

endmodule

// ----- src/msp_afs_front.sv -----
// Front end: accepts updates, applies the boot and interval rules and queues frame requests.
module msp_afs_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [msp_afs_pkg::TimeW-1:0]      now_ms_i,
  input  logic                               armed_i,
  input  logic [msp_afs_pkg::CfgW-1:0]       boot_delay_i,
  input  logic [msp_afs_pkg::CfgW-1:0]       send_interval_i,
  output logic                               push_valid_o,
  input  logic                               push_ready_i,
  output msp_afs_pkg::q_entry_t              push_entry_o
);

  logic                          started_q, started_d;
  logic [msp_afs_pkg::TimeW-1:0] tx_time_q, tx_time_d;
  logic [msp_afs_pkg::TimeW-1:0] elapsed;
  logic                          fire;
  logic                          accept;

  assign elapsed = now_ms_i - tx_time_q;

  always_comb begin
    if (!started_q) begin
      fire = now_ms_i >= {{(msp_afs_pkg::TimeW-msp_afs_pkg::CfgW){1'b0}}, boot_delay_i};
    end else begin
      fire = elapsed >= {{(msp_afs_pkg::TimeW-msp_afs_pkg::CfgW){1'b0}}, send_interval_i};
    end
  end

  // An update that sends nothing is still taken only when the queue has room.
  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && push_ready_i;
  assign push_valid_o = in_valid_i && fire;

  always_comb begin
    push_entry_o.kind  = started_q ? msp_afs_pkg::FK_ARMING : msp_afs_pkg::FK_HANDSHAKE;
    push_entry_o.armed = armed_i;
  end

  always_comb begin
    started_d = started_q;
    tx_time_d = tx_time_q;
    if (accept && fire) begin
      started_d = 1'b1;
      tx_time_d = now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      tx_time_q <= '0;
    end else begin
      started_q <= started_d;
      tx_time_q <= tx_time_d;
    end
  end

  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(started_q)) else $error("handshake flag cleared after it was set");

  a_handshake_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fire && started_q) |-> (push_entry_o.kind == msp_afs_pkg::FK_ARMING))
    else $error("handshake requested twice");

endmodule

// ----- src/msp_afs_queue.sv -----
// Short request queue between the front end and the byte sequencer.
module msp_afs_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  msp_afs_pkg::q_entry_t push_entry_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output msp_afs_pkg::q_entry_t pop_entry_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);

  msp_afs_pkg::q_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count beyond depth");

endmodule

// ----- src/msp_afs_back.sv -----
// Back end: walks the bytes of each queued request into a registered output stage.
module msp_afs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  msp_afs_pkg::q_entry_t pop_entry_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output msp_afs_pkg::out_beat_t out_beat_o
);

  logic [msp_afs_pkg::BeatIdxW-1:0] idx_q, idx_d;
  logic                             out_valid_q, out_valid_d;
  msp_afs_pkg::out_beat_t           out_beat_q;
  msp_afs_pkg::out_beat_t           beat;
  logic                             load;
  logic                             step;

  assign beat = msp_afs_pkg::frame_beat(pop_entry_i, idx_q);
  // The output register takes a new beat when it is empty or being drained.
  assign load = !out_valid_q || out_ready_i;
  assign step = pop_valid_i && load;
  assign pop_ready_o = load && beat.run_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = pop_valid_i;
    end
    if (step) begin
      idx_d = beat.run_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_beat_q <= beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid_i |-> (idx_q <= msp_afs_pkg::HandshakeLastIdx &&
      (pop_entry_i.kind == msp_afs_pkg::FK_HANDSHAKE || idx_q <= msp_afs_pkg::ArmingLastIdx)))
    else $error("byte index past the end of its run");

  a_run_closes_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && beat.run_last) |-> beat.frame_last)
    else $error("run ended inside a frame");

endmodule

// ----- dv/tb_msp_arming_frame_sender.sv -----
// Self-checking testbench of the MSP arming frame sender: stream stimulus, APB setup, byte checks.

class msp_frame_scoreboard;
  logic [msp_afs_pkg::CfgW-1:0]  boot_delay;
  logic [msp_afs_pkg::CfgW-1:0]  send_interval;
  logic                          started;
  logic [msp_afs_pkg::TimeW-1:0] tx_time;
  msp_afs_pkg::out_beat_t        run_bytes[$];
  msp_afs_pkg::out_beat_t        expected_bytes[$];
  int unsigned                   mismatches;

  function new();
    boot_delay    = msp_afs_pkg::BootDelayReset;
    send_interval = msp_afs_pkg::SendIntervalReset;
    started       = 1'b0;
    tx_time       = '0;
    mismatches    = 0;
  endfunction

  function void set_config(logic sel, logic [msp_afs_pkg::CfgW-1:0] value);
    if (sel == msp_afs_pkg::RegBootDelay) begin
      boot_delay = value;
    end else begin
      send_interval = value;
    end
  endfunction

  function int pending();
    return expected_bytes.size();
  endfunction

  function void report_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("Mismatch %0d: %s", mismatches, what);
  endfunction

  function void push_frame(logic [7:0] cmd, logic with_payload, logic armed);
    msp_afs_pkg::out_beat_t b;
    logic [7:0]             size;
    logic [7:0]             sum;
    size = with_payload ? 8'd1 : 8'd0;
    sum  = size ^ cmd;
    b.frame_last = 1'b0;
    b.run_last   = 1'b0;
    b.tx_byte = msp_afs_pkg::HdrDollar; run_bytes.push_back(b);
    b.tx_byte = msp_afs_pkg::HdrM;      run_bytes.push_back(b);
    b.tx_byte = msp_afs_pkg::HdrLt;     run_bytes.push_back(b);
    b.tx_byte = size;                   run_bytes.push_back(b);
    b.tx_byte = cmd;                    run_bytes.push_back(b);
    if (with_payload) begin
      b.tx_byte = {7'b0, armed};
      sum ^= b.tx_byte;
      run_bytes.push_back(b);
    end
    b.tx_byte    = sum;
    b.frame_last = 1'b1;
    run_bytes.push_back(b);
  endfunction

  // Works out the bytes that one accepted update produces.
  function void note_update(logic [msp_afs_pkg::TimeW-1:0] now, logic armed);
    logic [msp_afs_pkg::TimeW-1:0] elapsed;
    run_bytes.delete();
    if (!started) begin
      if (now < {16'h0, boot_delay}) return;
      push_frame(msp_afs_pkg::CmdApiVersion, 1'b0, 1'b0);
      push_frame(msp_afs_pkg::CmdStatus, 1'b0, 1'b0);
      started = 1'b1;
      tx_time = now;
    end else begin
      elapsed = now - tx_time;
      if (elapsed < {16'h0, send_interval}) return;
      tx_time = now;
      push_frame(msp_afs_pkg::CmdSetArming, 1'b1, armed);
    end
    run_bytes[run_bytes.size()-1].run_last = 1'b1;
    foreach (run_bytes[i]) expected_bytes.push_back(run_bytes[i]);
  endfunction

  function void check_beat(logic [7:0] tx_byte, logic frame_last, logic run_last);
    msp_afs_pkg::out_beat_t e;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h (tlast %b, tuser %b)",
                                tx_byte, frame_last, run_last));
      return;
    end
    e = expected_bytes.pop_front();
    if (tx_byte !== e.tx_byte)
      report_mismatch($sformatf("tx_byte expected %02h, got %02h", e.tx_byte, tx_byte));
    if (frame_last !== e.frame_last)
      report_mismatch($sformatf("frame_last expected %b, got %b", e.frame_last, frame_last));
    if (run_last !== e.run_last)
      report_mismatch($sformatf("run_last expected %b, got %b", e.run_last, run_last));
  endfunction
endclass

module tb_msp_arming_frame_sender;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainPad     = 16;
  localparam int unsigned PhaseItems   = 47;
  localparam int unsigned RandomPhases = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;    // now_ms[31:0], armed[32], zero fill [39:33]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // tx_byte[7:0]
  logic        m_axis_tlast;
  logic        m_axis_tuser;         // run_last[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  msp_frame_scoreboard sb = new();

  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;

  msp_arming_frame_sender u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: a requested long hold-off first, otherwise short random stall bursts.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left    = $urandom_range(0, 5);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  task automatic offer_update(input logic [31:0] now, input logic armed);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'b0, armed, now};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_update(now, armed);
  endtask

  // Waits until every expected byte is out, plus time for updates that send nothing.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainPad) @(posedge clk_i);
  endtask

  // One write followed by a read back of the same register.
  task automatic cfg_write(input logic sel, input logic [msp_afs_pkg::CfgW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = {16'h0, value};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    sb.set_config(sel, value);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata !== {16'h0, value})
      sb.report_mismatch($sformatf("register at %0d reads %08h, expected %08h",
                                   {sel, 2'b00}, prdata, {16'h0, value}));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  initial begin
    logic [31:0]                  clock_ms;
    logic [31:0]                  step_ms;
    logic [msp_afs_pkg::CfgW-1:0] gap_ms;
    int                           ph;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default boot delay holds back early updates.
    offer_update(32'd0, 1'b0);
    offer_update(32'd2999, 1'b1);
    drain();
    cfg_write(msp_afs_pkg::RegBootDelay, 16'hFFFF);
    offer_update(32'd3000, 1'b1);
    offer_update(32'd65534, 1'b0);
    offer_update(32'd65535, 1'b1);      // handshake frames
    offer_update(32'd66034, 1'b0);      // one ms short of the interval
    offer_update(32'd66035, 1'b0);
    offer_update(32'd66535, 1'b1);
    offer_update(32'd16, 1'b1);         // time going backwards reads as a long elapsed time
    offer_update(32'hFFFF_FFFF, 1'b0);
    offer_update(32'd498, 1'b1);        // wrapped elapsed time of 499
    offer_update(32'd499, 1'b1);
    drain();
    cfg_write(msp_afs_pkg::RegSendInterval, 16'd0);  // a zero interval sends on every update
    offer_update(32'd499, 1'b0);
    offer_update(32'd499, 1'b1);
    offer_update(32'h8000_0000, 1'b1);
    drain();
    cfg_write(msp_afs_pkg::RegSendInterval, 16'hFFFF);
    cfg_write(msp_afs_pkg::RegBootDelay, 16'h0000);
    offer_update(32'h8000_FFFE, 1'b0);
    offer_update(32'h8000_FFFF, 1'b1);
    offer_update(32'h8000_FFFF, 1'b0);
    clock_ms = 32'h8000_FFFF;

    for (ph = 0; ph < RandomPhases; ph++) begin
      drain();
      case (ph)
        0: gap_ms = 16'd500;
        1: gap_ms = 16'd1;
        2: gap_ms = 16'($urandom_range(0, 65535));
        3: gap_ms = 16'd0;
        4: gap_ms = 16'hFFFF;
        default: gap_ms = 16'($urandom_range(1, 3000));
      endcase
      cfg_write(msp_afs_pkg::RegSendInterval, gap_ms);
      if (ph == 1) cfg_write(msp_afs_pkg::RegBootDelay, 16'($urandom_range(0, 65535)));
      if (ph == 2) hold_req = 1'b1;
      if (ph == RandomPhases - 1) quiet = 1'b1;
      repeat (PhaseItems) begin
        case ($urandom_range(0, 9))
          0: step_ms = $urandom;
          1: step_ms = -$urandom_range(1, 1000);
          2: step_ms = (gap_ms == 0) ? 32'd0 : $urandom_range(0, gap_ms - 1);
          3: step_ms = {16'h0, gap_ms};
          default: step_ms = {16'h0, gap_ms} + $urandom_range(0, 2 * gap_ms + 10);
        endcase
        clock_ms += step_ms;
        offer_update(clock_ms, 1'($urandom_range(0, 1)));
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- msp_arming_frame_sender.f -----
src/msp_afs_pkg.sv
src/msp_afs_front.sv
src/msp_afs_queue.sv
src/msp_afs_back.sv
src/msp_arming_frame_sender.sv
dv/tb_msp_arming_frame_sender.sv
